// ===== rtl/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Filter type codes, configuration register map, default sizes and the
// Paeth predictor shared by the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

	// default sizes of the line store and the pixel history
	localparam int MAX_ROW_BYTES_DEF   = 8192;
	localparam int MAX_PIXEL_BYTES_DEF = 8;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 14;
	localparam int PIX_BYTES_W = 4;
	localparam int ROW_LEN_W   = 14;

	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH  = 1'b1;

	// filter type codes as carried in the first byte of each row
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	// Paeth predictor: neighbor nearest to a + b - c, ties to a, then b
	function automatic logic [7:0] paeth_pred(
		input logic [7:0] a,
		input logic [7:0] b,
		input logic [7:0] c
	);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [7:0]        sel;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			sel = a;
		end else if (db <= dc) begin
			sel = b;
		end else begin
			sel = c;
		end
		return sel;
	endfunction

endpackage

// ===== rtl/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs raw image bytes from the inflated, filtered PNG byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the output is not stalled and
// returns one reconstructed byte per data byte: the byte above is read into
// the reconstruct stage, then the result goes to the output register. The
// filter byte at the head of each row returns nothing. The sustained rate of
// one byte per cycle is set by the left-neighbor loop in the reconstruct
// stage: the previous result goes through the Sub/Average/Paeth predictor
// and the final add combinationally. The prior-row line store is a single
// memory read at acceptance and written when the byte leaves the reconstruct
// stage; a row always opens with a filter byte, so a read never meets a
// pending write to the same column. The line store needs no clearing pass
// after reset: the first row after reset or an image start ignores it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data,
	// filtered byte stream in
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            image_start,
	// reconstructed bytes out
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      pixel_byte,
	output logic                            row_last,
	output logic                            filter_bad
);
	import psu_pkg::*;

	localparam int CW    = $clog2(MAX_ROW_BYTES);
	localparam int LenW  = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
	localparam int PW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// configuration registers
	logic [PIX_BYTES_W-1:0] pixel_bytes_q;
	logic [ROW_LEN_W-1:0]   row_length_q;

	// row control
	logic [CW-1:0] col_q;
	filt_t         filt_q;
	logic          bad_q;
	logic          awaiting_q;
	logic          first_row_q;

	// reconstruct stage
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic [CW-1:0] col_s1;
	logic          has_left_s1;
	logic          first_s1;
	filt_t         filt_s1;
	logic          bad_s1;
	logic          last_s1;
	logic [7:0]    prior_rd_s1;

	// line store and pixel history
	logic [7:0] prior_row_mem [MAX_ROW_BYTES];
	logic [7:0] left_hist_q   [MAX_PIXEL_BYTES];
	logic [7:0] upleft_hist_q [MAX_PIXEL_BYTES];

	// output register
	logic [7:0] pixel_byte_q;
	logic       row_last_q;
	logic       filter_bad_q;
	logic       out_valid_q;

	logic                   in_fire;
	logic                   s1_go;
	logic                   filt_byte;
	logic                   data_fire;
	logic [PIX_BYTES_W-1:0] pb_eff;
	logic [LenW-1:0]        len_eff;
	logic [LenW-1:0]        rl_ext;
	logic                   has_left;
	logic                   last;
	logic [PW-1:0]          hist_idx;
	logic [7:0]             a_val;
	logic [7:0]             b_val;
	logic [7:0]             c_val;
	logic [8:0]             avg_sum;
	logic [7:0]             pred;
	logic [7:0]             res;

	// clamp the registers to their working ranges
	always_comb begin
		rl_ext = LenW'(row_length_q);
		if (pixel_bytes_q == '0) begin
			pb_eff = PIX_BYTES_W'(1);
		end else if (pixel_bytes_q > PIX_BYTES_W'(MAX_PIXEL_BYTES)) begin
			pb_eff = PIX_BYTES_W'(MAX_PIXEL_BYTES);
		end else begin
			pb_eff = pixel_bytes_q;
		end
		if (rl_ext == '0) begin
			len_eff = LenW'(1);
		end else if (rl_ext > LenW'(MAX_ROW_BYTES)) begin
			len_eff = LenW'(MAX_ROW_BYTES);
		end else begin
			len_eff = rl_ext;
		end
	end

	// handshake and byte classification
	assign s1_go     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_go;
	assign in_fire   = in_valid && in_ready;
	assign filt_byte = image_start || awaiting_q;
	assign data_fire = in_fire && !filt_byte;
	assign has_left  = LenW'(col_q) >= LenW'(pb_eff);
	assign last      = (LenW'(col_q) + LenW'(1)) >= len_eff;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIX_BYTES_W'(1);
			row_length_q  <= ROW_LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[PIX_BYTES_W-1:0];
				CFG_ROW_LENGTH:  row_length_q  <= cfg_data[ROW_LEN_W-1:0];
				default:         ;
			endcase
		end
	end

	// latch filter bytes, advance the column on data bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			filt_q      <= FILT_NONE;
			bad_q       <= 1'b0;
			awaiting_q  <= 1'b1;
			first_row_q <= 1'b1;
		end else if (in_fire) begin
			if (filt_byte) begin
				if (data_byte > FILT_MAX_CODE) begin
					filt_q <= FILT_NONE;
					bad_q  <= 1'b1;
				end else begin
					filt_q <= filt_t'(data_byte[2:0]);
					bad_q  <= 1'b0;
				end
				awaiting_q <= 1'b0;
				col_q      <= '0;
				if (image_start) begin
					first_row_q <= 1'b1;
				end
			end else if (last) begin
				col_q       <= '0;
				awaiting_q  <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// reconstruct stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= data_fire;
		end
	end

	// reconstruct stage payload
	always_ff @(posedge clk) begin
		if (data_fire) begin
			data_s1     <= data_byte;
			col_s1      <= col_q;
			has_left_s1 <= has_left;
			first_s1    <= first_row_q;
			filt_s1     <= filt_q;
			bad_s1      <= bad_q;
			last_s1     <= last;
		end
	end

	// line store: read the byte above on accept, write the result on leave
	always_ff @(posedge clk) begin
		if (s1_go) begin
			prior_row_mem[col_s1] <= res;
		end
		if (data_fire) begin
			prior_rd_s1 <= prior_row_mem[col_q];
		end
	end

	// pick neighbors and predict
	always_comb begin
		hist_idx = PW'(pb_eff - PIX_BYTES_W'(1));
		a_val    = has_left_s1 ? left_hist_q[hist_idx] : 8'd0;
		b_val    = first_s1 ? 8'd0 : prior_rd_s1;
		c_val    = (has_left_s1 && !first_s1) ? upleft_hist_q[hist_idx] : 8'd0;
		avg_sum  = {1'b0, a_val} + {1'b0, b_val};
		unique case (filt_s1)
			FILT_SUB:   pred = a_val;
			FILT_UP:    pred = b_val;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
			default:    pred = 8'd0;
		endcase
		res = data_s1 + pred;
	end

	// shift the left and upper-left history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_hist_q[i]   <= 8'd0;
				upleft_hist_q[i] <= 8'd0;
			end
		end else if (s1_go) begin
			for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
				left_hist_q[i]   <= left_hist_q[i-1];
				upleft_hist_q[i] <= upleft_hist_q[i-1];
			end
			left_hist_q[0]   <= res;
			upleft_hist_q[0] <= b_val;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_go) begin
			pixel_byte_q <= res;
			row_last_q   <= last_s1;
			filter_bad_q <= bad_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign row_last   = row_last_q;
	assign filter_bad = filter_bad_q;

	// a data byte never reads the column that the leaving byte writes
	a_no_rw_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		data_fire && s1_go |-> col_q != col_s1)
		else $error("line store read meets write to the same column");

	// a stalled reconstruct stage keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(col_s1) && $stable(data_s1))
		else $error("reconstruct stage lost a stalled byte");

	// an image start opens a fresh first row
	a_image_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && image_start |=> !awaiting_q && first_row_q && col_q == '0)
		else $error("image start did not restart the row");

	// the column stays inside the line store
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		LenW'(col_q) < LenW'(MAX_ROW_BYTES))
		else $error("column past the line store");

endmodule
